@@ rtl/utf8dw_pkg.sv @@
// utf8dw_pkg: shared types and constants for the UTF-8 display width core.
// Used by the decode stage and the top level; depends on nothing.

package utf8dw_pkg;

   // Byte class masks and prefixes
   localparam logic [7:0] LEAD2_MASK   = 8'hE0;
   localparam logic [7:0] LEAD2_PREFIX = 8'hC0;
   localparam logic [7:0] LEAD3_MASK   = 8'hF0;
   localparam logic [7:0] LEAD3_PREFIX = 8'hE0;

   // Held byte counts of a pending sequence
   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_ONE  = 2'd1;
   localparam logic [1:0] HELD_TWO  = 2'd2;

   localparam int unsigned OUT_BITS = 16;

   // Decode result for one byte
   typedef struct packed {
      logic [7:0] lead;
      logic [7:0] second;
      logic [1:0] count;
      logic [1:0] cols;    // columns to add this word, 0..2
   } decode_type;

endpackage

@@ rtl/utf8dw_if.sv @@
// utf8dw_if: valid/ready channel interfaces for request and response words.
// Uses utf8dw_pkg for the response width.

interface utf8dw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface utf8dw_rsp_if
   import utf8dw_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [OUT_BITS-1:0] total_width;

   modport source (output valid, output total_width, input ready);
   modport sink   (input valid, input total_width, output ready);
endinterface

@@ rtl/utf8dw_decode.sv @@
// utf8dw_decode: combinational UTF-8 sequence step and East Asian wide check.
// Depends on utf8dw_pkg.

module utf8dw_decode
   import utf8dw_pkg::*;
(
   input  logic [7:0]  held_lead,
   input  logic [7:0]  held_second,
   input  logic [1:0]  held_count,
   input  logic [7:0]  byte_value,
   input  logic        last_byte,
   output decode_type  result
);

   logic [15:0] code_point;
   logic        wide;
   logic [7:0]  lead_nxt;
   logic [7:0]  second_nxt;
   logic [1:0]  count_nxt;
   logic [1:0]  cols_step;

   // Code point of a completed three-byte sequence
   assign code_point = {held_lead[3:0], held_second[5:0], byte_value[5:0]};

   // Wide ranges
   always_comb begin
      wide = (code_point >= 16'h1100 && code_point <= 16'h11FF) ||
             (code_point >= 16'h2E80 && code_point <= 16'h303F) ||
             (code_point >= 16'h3040 && code_point <= 16'h33FF) ||
             (code_point >= 16'h3400 && code_point <= 16'h4DBF) ||
             (code_point >= 16'h4E00 && code_point <= 16'h9FFF) ||
             (code_point >= 16'hA000 && code_point <= 16'hA4CF) ||
             (code_point >= 16'hAC00 && code_point <= 16'hD7AF) ||
             (code_point >= 16'hF900 && code_point <= 16'hFAFF) ||
             (code_point >= 16'hFF00 && code_point <= 16'hFFEF);
   end

   // Sequence step
   always_comb begin
      lead_nxt   = held_lead;
      second_nxt = held_second;
      count_nxt  = held_count;
      cols_step  = 2'd0;
      if (held_count == HELD_NONE) begin
         if ((byte_value & LEAD2_MASK) == LEAD2_PREFIX ||
             (byte_value & LEAD3_MASK) == LEAD3_PREFIX) begin
            lead_nxt  = byte_value;
            count_nxt = HELD_ONE;
         end else begin
            // ASCII or stray byte
            cols_step = 2'd1;
         end
      end else if (held_count == HELD_ONE &&
                   (held_lead & LEAD2_MASK) == LEAD2_PREFIX) begin
         cols_step  = 2'd1;
         lead_nxt   = 8'h00;
         second_nxt = 8'h00;
         count_nxt  = HELD_NONE;
      end else if (held_count == HELD_ONE) begin
         second_nxt = byte_value;
         count_nxt  = HELD_TWO;
      end else begin
         cols_step  = wide ? 2'd2 : 2'd1;
         lead_nxt   = 8'h00;
         second_nxt = 8'h00;
         count_nxt  = HELD_NONE;
      end
   end

   // End of string: flush held bytes at one column each, then clear
   always_comb begin
      result.lead   = lead_nxt;
      result.second = second_nxt;
      result.count  = count_nxt;
      result.cols   = cols_step;
      if (last_byte) begin
         // a held byte only remains when this word added nothing
         result.cols   = cols_step | count_nxt;
         result.lead   = 8'h00;
         result.second = 8'h00;
         result.count  = HELD_NONE;
      end
   end

endmodule

@@ rtl/utf8dw_core_top.sv @@
// utf8_display_width_core: top level, input register, width accumulator,
// response register. Depends on utf8dw_pkg, utf8dw_if and utf8dw_decode.
//
//  channel | dir | payload                          | word
//  req     | in  | byte_value[7:0], last_byte       | one string byte
//  rsp     | out | total_width[15:0]                | width of one string
//
// One word per cycle sustained unless rsp stalls a last byte; rsp valid follows
// the req accept (input register, then decode and accumulate into the rsp register).
// Synchronous active-high reset clears the pipeline and the running count.
// A stalled rsp only blocks the stage when its word carries last_byte;
// other bytes keep flowing into the accumulator.

module utf8_display_width_core
   import utf8dw_pkg::*;
#(
   parameter int unsigned COUNT_BITS = 16
) (
   input logic           clock,
   input logic           reset,
   utf8dw_req_if.sink    req,
   utf8dw_rsp_if.source  rsp
);

   // Input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       s1_advance;

   // Sequence and count state
   logic [7:0]            lead_ff, lead_in;
   logic [7:0]            second_ff, second_in;
   logic [1:0]            count_ff, count_in;
   logic [COUNT_BITS-1:0] width_ff, width_in;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0] rsp_width_ff, rsp_width_in;

   decode_type            dec;
   logic [COUNT_BITS:0]   sum;
   logic [COUNT_BITS-1:0] sat;
   logic [OUT_BITS-1:0]   clamped;

   utf8dw_decode u_decode (
      .held_lead   (lead_ff),
      .held_second (second_ff),
      .held_count  (count_ff),
      .byte_value  (s1_byte_ff),
      .last_byte   (s1_last_ff),
      .result      (dec)
   );

   // Stage handshake
   assign s1_advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp.ready);
   assign req.ready  = !s1_valid_ff || s1_advance;
   assign s1_valid_in = (req.valid && req.ready) || (s1_valid_ff && !s1_advance);

   // Saturating add
   assign sum = {1'b0, width_ff} + {{(COUNT_BITS-1){1'b0}}, dec.cols};
   assign sat = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];

   // Limit to the output field
   generate
      if (COUNT_BITS > OUT_BITS) begin : g_clamp
         assign clamped = (|sat[COUNT_BITS-1:OUT_BITS]) ? {OUT_BITS{1'b1}}
                                                        : sat[OUT_BITS-1:0];
      end else if (COUNT_BITS == OUT_BITS) begin : g_same
         assign clamped = sat;
      end else begin : g_extend
         assign clamped = {{(OUT_BITS-COUNT_BITS){1'b0}}, sat};
      end
   endgenerate

   // Next state
   always_comb begin
      lead_in      = lead_ff;
      second_in    = second_ff;
      count_in     = count_ff;
      width_in     = width_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_width_in = rsp_width_ff;
      if (s1_advance) begin
         lead_in   = dec.lead;
         second_in = dec.second;
         count_in  = dec.count;
         width_in  = s1_last_ff ? '0 : sat;
         if (s1_last_ff) begin
            rsp_valid_in = 1'b1;
            rsp_width_in = clamped;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lead_ff      <= 8'h00;
         second_ff    <= 8'h00;
         count_ff     <= HELD_NONE;
         width_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         lead_ff      <= lead_in;
         second_ff    <= second_in;
         count_ff     <= count_in;
         width_ff     <= width_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_byte_ff <= req.byte_value;
         s1_last_ff <= req.last_byte;
      end
      rsp_width_ff <= rsp_width_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.total_width = rsp_width_ff;

`ifndef SYNTHESIS
   // Held count never reaches three
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("held byte count out of range");

   // End of string clears the sequence and the running count
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_last_ff) |=> (width_ff == '0 && count_ff == HELD_NONE))
      else $error("state not cleared after last byte");

   // A new response only follows a last byte leaving the input stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(s1_advance && s1_last_ff))
      else $error("response without a last byte");

   // Non-last bytes never wait on the response side
   a_no_stall_mid: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_last_ff) |-> s1_advance)
      else $error("mid-string byte stalled");
`endif

endmodule
